[src/tks_pkg.sv]
// ----------------------------------------------------------------------------
// tks_pkg
// Shared sizes, register codes and the controller state type of the
// top-k running sum block.
// ----------------------------------------------------------------------------
package tks_pkg;

    localparam int CAPACITY    = 1024;
    localparam int VALUE_W     = 32;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int FILL_W      = ADDR_W + 1;
    localparam int IDX_W       = FILL_W + 1;
    localparam int SUM_W       = 42;
    localparam int CNT_W       = 10;
    localparam int KEPT_W      = 10;

    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 56;

    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;
    localparam int REG_IDX_W   = APB_AW - 2;

    localparam logic [REG_IDX_W-1:0] REG_MAX_KEPT = '0;

    localparam logic [FILL_W-1:0] CAP_FILL = FILL_W'(CAPACITY);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROOT,
        ST_UP_RD,
        ST_UP_CMP,
        ST_DN_RD,
        ST_DN_CMP,
        ST_DONE
    } tks_state_t;

endpackage

[src/tks_ram.sv]
// ----------------------------------------------------------------------------
// tks_ram
// Generic synchronous RAM: one write port, two read ports, registered reads.
// ----------------------------------------------------------------------------
module tks_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] ra_addr,
    output logic [WIDTH-1:0]         ra_data,
    input  logic [$clog2(DEPTH)-1:0] rb_addr,
    output logic [WIDTH-1:0]         rb_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        ra_data <= mem[ra_addr];
        rb_data <= mem[rb_addr];
    end

endmodule

[src/top_k_running_sum.sv]
// ----------------------------------------------------------------------------
// top_k_running_sum
// Running sum of the largest max_kept values seen since reset, kept in a
// binary min-heap held in on-chip RAM.
// ----------------------------------------------------------------------------
// Usage:
//   s_tvalid/s_tready/s_tdata carry one 32-bit value per word. For each
//   accepted word one result word leaves on m_tvalid/m_tready/m_tdata:
//   top_sum in bits 41:0 and held_count in bits 51:42.
//   max_kept sits at APB byte address 0; write it only while the block is
//   idle. Writes with paddr[2] set are ignored.
// Operation:
//   An insert sifts up through ST_UP_RD and ST_UP_CMP at each heap level; a
//   replacement reads the root in ST_ROOT and sifts down through ST_DN_RD and
//   ST_DN_CMP at each level (both children are read together on the two RAM
//   read ports). A dropped value skips the sift. The sift loop over the
//   single heap RAM sets the pace; the block takes one item at a time.
// Reset:
//   rst_n clears the fill count, the sum and max_kept. The heap RAM is not
//   cleared; only entries below the fill count are ever used.
// Stall:
//   The result waits in an output register, and the next value is taken
//   meanwhile; a second result holds in the final state until m_tready.
// ----------------------------------------------------------------------------
module top_k_running_sum (
    input  logic                             clk,
    input  logic                             rst_n,
    // value [31:0]
    input  logic [tks_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // top_sum [41:0], held_count [51:42], zero [55:52]
    output logic [tks_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tks_pkg::APB_AW-1:0]       paddr,
    input  logic [tks_pkg::APB_DW-1:0]       pwdata,
    output logic [tks_pkg::APB_DW-1:0]       prdata,
    output logic                             pready
);

    tks_pkg::tks_state_t state_reg, state_next;

    logic [tks_pkg::VALUE_W-1:0] val_reg,   val_next;
    logic [tks_pkg::ADDR_W-1:0]  pos_reg,   pos_next;
    logic [tks_pkg::FILL_W-1:0]  fill_reg,  fill_next;
    logic [tks_pkg::SUM_W-1:0]   sum_reg,   sum_next;
    logic [tks_pkg::KEPT_W-1:0]  kept_reg,  kept_next;
    logic                        m_valid_reg, m_valid_next;
    logic [tks_pkg::SUM_W-1:0]   m_sum_reg, m_sum_next;
    logic [tks_pkg::CNT_W-1:0]   m_cnt_reg, m_cnt_next;

    logic                        ram_we;
    logic [tks_pkg::ADDR_W-1:0]  ram_waddr;
    logic [tks_pkg::VALUE_W-1:0] ram_wdata;
    logic [tks_pkg::ADDR_W-1:0]  ram_ra_addr;
    logic [tks_pkg::ADDR_W-1:0]  ram_rb_addr;
    logic [tks_pkg::VALUE_W-1:0] ram_ra_data;
    logic [tks_pkg::VALUE_W-1:0] ram_rb_data;

    logic                        in_fire;
    logic                        cfg_wr;
    logic                        out_free;
    logic [tks_pkg::FILL_W-1:0]  kept_ext;
    logic [tks_pkg::FILL_W-1:0]  limit;
    logic                        do_push;
    logic [tks_pkg::ADDR_W-1:0]  pos_m1;
    logic [tks_pkg::ADDR_W-1:0]  up_idx;
    logic [tks_pkg::IDX_W-1:0]   lo_idx;
    logic [tks_pkg::IDX_W-1:0]   hi_idx;
    logic                        lo_ok;
    logic                        hi_ok;
    logic                        take_lo;
    logic                        take_hi;
    logic [tks_pkg::VALUE_W-1:0] lo_best;

    tks_ram #(
        .WIDTH (tks_pkg::VALUE_W),
        .DEPTH (tks_pkg::CAPACITY)
    ) u_heap_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .ra_addr (ram_ra_addr),
        .ra_data (ram_ra_data),
        .rb_addr (ram_rb_addr),
        .rb_data (ram_rb_data)
    );

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[tks_pkg::APB_AW-1:2] == tks_pkg::REG_MAX_KEPT);

    always_comb
    begin
        kept_next = kept_reg;
        if (cfg_wr)
        begin
            kept_next = pwdata[tks_pkg::KEPT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[tks_pkg::APB_AW-1:2] == tks_pkg::REG_MAX_KEPT)
        begin
            prdata = tks_pkg::APB_DW'(kept_reg);
        end
    end

    // ------------------------------------------------------------------
    // Index arithmetic
    // ------------------------------------------------------------------
    assign s_tready = (state_reg == tks_pkg::ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign kept_ext = tks_pkg::FILL_W'(kept_reg);
    assign limit    = (kept_ext > tks_pkg::CAP_FILL) ? tks_pkg::CAP_FILL : kept_ext;
    assign do_push  = (fill_reg < limit);

    assign pos_m1 = pos_reg - 1'b1;
    assign up_idx = {1'b0, pos_m1[tks_pkg::ADDR_W-1:1]};
    assign lo_idx = {1'b0, pos_reg, 1'b1};
    assign hi_idx = lo_idx + 1'b1;
    assign lo_ok  = (lo_idx < tks_pkg::IDX_W'(fill_reg));
    assign hi_ok  = (hi_idx < tks_pkg::IDX_W'(fill_reg));

    // pick the smaller child if it is below the value being sifted
    assign take_lo = (ram_ra_data < val_reg);
    assign lo_best = take_lo ? ram_ra_data : val_reg;
    assign take_hi = hi_ok && (ram_rb_data < lo_best);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tks_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (do_push)
                    begin
                        state_next = tks_pkg::ST_UP_RD;
                    end
                    else if (fill_reg != '0)
                    begin
                        state_next = tks_pkg::ST_ROOT;
                    end
                    else
                    begin
                        state_next = tks_pkg::ST_DONE;
                    end
                end
            end
            tks_pkg::ST_ROOT:
            begin
                state_next = (val_reg > ram_ra_data) ? tks_pkg::ST_DN_RD : tks_pkg::ST_DONE;
            end
            tks_pkg::ST_UP_RD:
            begin
                state_next = (pos_reg == '0) ? tks_pkg::ST_DONE : tks_pkg::ST_UP_CMP;
            end
            tks_pkg::ST_UP_CMP:
            begin
                state_next = (ram_ra_data > val_reg) ? tks_pkg::ST_UP_RD : tks_pkg::ST_DONE;
            end
            tks_pkg::ST_DN_RD:
            begin
                state_next = lo_ok ? tks_pkg::ST_DN_CMP : tks_pkg::ST_DONE;
            end
            tks_pkg::ST_DN_CMP:
            begin
                state_next = (take_lo || take_hi) ? tks_pkg::ST_DN_RD : tks_pkg::ST_DONE;
            end
            tks_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = tks_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tks_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and RAM control
    // ------------------------------------------------------------------
    always_comb
    begin
        val_next     = val_reg;
        pos_next     = pos_reg;
        fill_next    = fill_reg;
        sum_next     = sum_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_sum_next   = m_sum_reg;
        m_cnt_next   = m_cnt_reg;
        ram_we       = 1'b0;
        ram_waddr    = pos_reg;
        ram_wdata    = val_reg;
        ram_ra_addr  = '0;
        ram_rb_addr  = hi_idx[tks_pkg::ADDR_W-1:0];

        unique case (state_reg)
            tks_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    val_next = s_tdata[tks_pkg::VALUE_W-1:0];
                    if (do_push)
                    begin
                        pos_next  = fill_reg[tks_pkg::ADDR_W-1:0];
                        fill_next = fill_reg + 1'b1;
                        sum_next  = sum_reg + tks_pkg::SUM_W'(s_tdata[tks_pkg::VALUE_W-1:0]);
                    end
                end
            end
            tks_pkg::ST_ROOT:
            begin
                pos_next = '0;
                if (val_reg > ram_ra_data)
                begin
                    sum_next = sum_reg - tks_pkg::SUM_W'(ram_ra_data)
                               + tks_pkg::SUM_W'(val_reg);
                end
            end
            tks_pkg::ST_UP_RD:
            begin
                ram_ra_addr = up_idx;
                if (pos_reg == '0)
                begin
                    ram_we = 1'b1;
                end
            end
            tks_pkg::ST_UP_CMP:
            begin
                ram_we = 1'b1;
                if (ram_ra_data > val_reg)
                begin
                    // move the parent down, climb one level
                    ram_wdata = ram_ra_data;
                    pos_next  = up_idx;
                end
            end
            tks_pkg::ST_DN_RD:
            begin
                ram_ra_addr = lo_idx[tks_pkg::ADDR_W-1:0];
                if (!lo_ok)
                begin
                    ram_we = 1'b1;
                end
            end
            tks_pkg::ST_DN_CMP:
            begin
                ram_we = 1'b1;
                if (take_hi)
                begin
                    ram_wdata = ram_rb_data;
                    pos_next  = hi_idx[tks_pkg::ADDR_W-1:0];
                end
                else if (take_lo)
                begin
                    ram_wdata = ram_ra_data;
                    pos_next  = lo_idx[tks_pkg::ADDR_W-1:0];
                end
            end
            tks_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_sum_next   = sum_reg;
                    m_cnt_next   = fill_reg[tks_pkg::CNT_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = tks_pkg::M_TDATA_W'({m_cnt_reg, m_sum_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= tks_pkg::ST_IDLE;
            fill_reg    <= '0;
            sum_reg     <= '0;
            kept_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            sum_reg     <= sum_next;
            kept_reg    <= kept_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg   <= val_next;
        pos_reg   <= pos_next;
        m_sum_reg <= m_sum_next;
        m_cnt_reg <= m_cnt_next;
    end

endmodule

[src/tks_checker.sv]
// ----------------------------------------------------------------------------
// tks_checker
// Port-level checks on the top-k running sum block, bound to the top level.
// ----------------------------------------------------------------------------
module tks_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [tks_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready
);

    logic                      in_fire;
    logic                      out_fire;
    logic [1:0]                pending_reg;
    logic [tks_pkg::SUM_W-1:0] last_sum_reg;
    logic [tks_pkg::CNT_W-1:0] last_cnt_reg;
    logic [tks_pkg::SUM_W-1:0] cur_sum;
    logic [tks_pkg::CNT_W-1:0] cur_cnt;

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;
    assign cur_sum  = m_tdata[tks_pkg::SUM_W-1:0];
    assign cur_cnt  = m_tdata[tks_pkg::SUM_W+tks_pkg::CNT_W-1:tks_pkg::SUM_W];

    // track items in flight and the last delivered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg  <= '0;
            last_sum_reg <= '0;
            last_cnt_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + {1'b0, in_fire} - {1'b0, out_fire};
            if (out_fire)
            begin
                last_sum_reg <= cur_sum;
                last_cnt_reg <= cur_cnt;
            end
        end
    end

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pending_reg != 2'd0)
        else $error("result word without an accepted value");

    a_sum_grows: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> cur_sum >= last_sum_reg)
        else $error("running sum decreased");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> cur_cnt == last_cnt_reg || cur_cnt == last_cnt_reg + 1'b1)
        else $error("held count moved by more than one");

endmodule

bind top_k_running_sum tks_checker u_tks_checker (.*);
